FILE: rtl/core/ray_voxel_traversal_defines.svh
// assertion macros for the ray voxel traversal checker
`ifndef RAY_VOXEL_TRAVERSAL_DEFINES_SVH
`define RAY_VOXEL_TRAVERSAL_DEFINES_SVH

// implication in the same cycle, held off during reset
`define RVT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ray_voxel_traversal check failed");

// implication in the next cycle, held off during reset
`define RVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ray_voxel_traversal check failed");

// implication in the next cycle, checked through reset
`define RVT_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ray_voxel_traversal check failed");

`endif

FILE: rtl/core/rvt_pkg.sv
// shared types and constants for the ray voxel traversal
package rvt_pkg;

  localparam int MAX_CELLS = 64;
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);
  localparam int PW        = 47;
  localparam int BD_W      = 31;
  localparam int KEY_W     = 24;
  localparam int MAG_W     = 16;
  localparam int SH_W      = 5;
  localparam int NPROD     = 9;
  localparam int KIDX_W    = 4;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} front_state_t;
  typedef enum logic {B_IDLE, B_RUN} back_state_t;

  typedef struct packed {
    logic [2:0][KEY_W-1:0] idx;
    logic [2:0][BD_W-1:0]  bd;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
    logic [5:0][PW-1:0]    pc;
    logic [2:0][PW-1:0]    dm;
    logic [SH_W-1:0]       sh;
  } rvt_ray_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } rvt_qctl_t;

endpackage

FILE: rtl/core/rvt_front.sv
// ray setup: cell index, boundary distances and cross products
module rvt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [31:0]        in_origin_x,
  input  logic signed [31:0]        in_origin_y,
  input  logic signed [31:0]        in_origin_z,
  input  logic signed [15:0]        in_dir_x,
  input  logic signed [15:0]        in_dir_y,
  input  logic signed [15:0]        in_dir_z,
  input  logic [30:0]               in_max_distance,
  input  logic [rvt_pkg::SH_W-1:0]  cell_shift,
  input  logic                      q_full,
  output logic                      q_push,
  output rvt_pkg::rvt_ray_t         q_data
);
  import rvt_pkg::*;

  front_state_t            state_r, state_nxt;
  logic [KIDX_W-1:0]       k_r, k_nxt;
  logic [2:0][KEY_W-1:0]   idx_r;
  logic [2:0][BD_W-1:0]    bd_r;
  logic [2:0]              neg_r;
  logic [2:0][MAG_W-1:0]   mag_r;
  logic [30:0]             dist_r;
  logic [SH_W-1:0]         sh_r;
  logic [NPROD-1:0][PW-1:0] prod_r;

  logic [SH_W-1:0]         sh_eff;
  logic signed [2:0][31:0] org;
  logic signed [2:0][15:0] dir;
  logic [24:0]             cq;
  logic [2:0][KEY_W-1:0]   idx_c;
  logic [2:0][BD_W-1:0]    bd_c;
  logic [2:0]              neg_c;
  logic [2:0][MAG_W-1:0]   mag_c;
  logic [30:0]             opa;
  logic [MAG_W-1:0]        opb;

  always_comb begin
    if (cell_shift < SH_W'(1)) sh_eff = SH_W'(1);
    else if (cell_shift > SH_W'(16)) sh_eff = SH_W'(16);
    else sh_eff = cell_shift;
  end

  assign org = {in_origin_z, in_origin_y, in_origin_x};
  assign dir = {in_dir_z, in_dir_y, in_dir_x};
  assign cq  = 25'(1) << (sh_eff + SH_W'(8));

  always_comb begin
    logic signed [31:0] sq;
    logic [24:0]        low;
    for (int i = 0; i < 3; i++) begin
      sq       = $signed(org[i]) >>> (sh_eff + SH_W'(8));
      idx_c[i] = sq[KEY_W-1:0];
      low      = {1'b0, org[i][23:0]} & (cq - 25'(1));
      neg_c[i] = !($signed(dir[i]) > 16'sd0);
      mag_c[i] = dir[i][15] ? 16'(-dir[i]) : dir[i];
      bd_c[i]  = neg_c[i] ? BD_W'(low) : BD_W'(cq - low);
    end
  end

  always_comb begin
    unique case (k_r)
      4'd0:    begin opa = bd_r[0]; opb = mag_r[1]; end
      4'd1:    begin opa = bd_r[1]; opb = mag_r[0]; end
      4'd2:    begin opa = bd_r[0]; opb = mag_r[2]; end
      4'd3:    begin opa = bd_r[2]; opb = mag_r[0]; end
      4'd4:    begin opa = bd_r[1]; opb = mag_r[2]; end
      4'd5:    begin opa = bd_r[2]; opb = mag_r[1]; end
      4'd6:    begin opa = dist_r;  opb = mag_r[0]; end
      4'd7:    begin opa = dist_r;  opb = mag_r[1]; end
      default: begin opa = dist_r;  opb = mag_r[2]; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        k_nxt = '0;
        if (start) state_nxt = F_MUL;
      end
      F_MUL: begin
        k_nxt = k_r + KIDX_W'(1);
        if (k_r == KIDX_W'(NPROD - 1)) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && start) begin
      idx_r  <= idx_c;
      bd_r   <= bd_c;
      neg_r  <= neg_c;
      mag_r  <= mag_c;
      dist_r <= in_max_distance;
      sh_r   <= sh_eff;
    end
    if (state_r == F_MUL) prod_r[k_r] <= PW'(opa) * PW'(opb);
  end

  assign busy       = (state_r != F_IDLE);
  assign q_data.idx = idx_r;
  assign q_data.bd  = bd_r;
  assign q_data.neg = neg_r;
  assign q_data.mag = mag_r;
  assign q_data.pc  = prod_r[5:0];
  assign q_data.dm  = prod_r[8:6];
  assign q_data.sh  = sh_r;

endmodule

FILE: rtl/core/rvt_queue.sv
// two-entry queue of set-up rays between front and back
module rvt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  rvt_pkg::rvt_qctl_t ctl_in,
  output rvt_pkg::rvt_qctl_t ctl_out,
  input  rvt_pkg::rvt_ray_t  wr_data,
  output rvt_pkg::rvt_ray_t  rd_data
);
  import rvt_pkg::*;

  rvt_ray_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign do_push = ctl_in.push && (cnt_r != 2'd2);
  assign do_pop  = ctl_in.pop && (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_data;
  end

  assign rd_data       = mem_r[rp_r];
  assign ctl_out.push  = do_push;
  assign ctl_out.pop   = do_pop;
  assign ctl_out.full  = (cnt_r == 2'd2);
  assign ctl_out.empty = (cnt_r == 2'd0);

endmodule

FILE: rtl/core/rvt_back.sv
// grid stepping: one cell key per cycle for the ray at the head of the queue
module rvt_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  rvt_pkg::rvt_ray_t           q_data,
  output logic                        out_valid,
  output logic [rvt_pkg::KEY_W-1:0]   out_key_x,
  output logic [rvt_pkg::KEY_W-1:0]   out_key_y,
  output logic [rvt_pkg::KEY_W-1:0]   out_key_z,
  output logic                        out_last,
  output logic                        out_truncated
);
  import rvt_pkg::*;

  back_state_t            state_r, state_nxt;
  logic [2:0][KEY_W-1:0]  idx_r;
  logic [2:0][BD_W-1:0]   bd_r;
  logic [2:0]             neg_r;
  logic [2:0][MAG_W-1:0]  mag_r;
  logic [5:0][PW-1:0]     pc_r;
  logic [2:0][PW-1:0]     dm_r;
  logic [SH_W-1:0]        sh_r;
  logic [CNT_W-1:0]       cnt_r;

  logic                   valid_r;
  logic [2:0][KEY_W-1:0]  key_r;
  logic                   last_r, trunc_r;

  logic                   n01, n02, n12;
  logic [1:0]             ax;
  logic                   zero_m, far, full, brk;
  logic [SH_W-1:0]        s8;
  logic [2:0][PW-1:0]     minc;
  logic [2:0][KEY_W-1:0]  key_c;

  assign n01 = (mag_r[0] != '0) && ((mag_r[1] == '0) || (pc_r[0] < pc_r[1]));
  assign n02 = (mag_r[0] != '0) && ((mag_r[2] == '0) || (pc_r[2] < pc_r[3]));
  assign n12 = (mag_r[1] != '0) && ((mag_r[2] == '0) || (pc_r[4] < pc_r[5]));

  always_comb begin
    if (n01) ax = n02 ? 2'd0 : 2'd2;
    else ax = n12 ? 2'd1 : 2'd2;
  end

  assign s8     = sh_r + SH_W'(8);
  assign zero_m = (mag_r[ax] == '0);
  assign far    = (PW'({bd_r[ax], 14'b0}) > dm_r[ax]);
  assign full   = (cnt_r >= CNT_W'(MAX_CELLS));
  assign brk    = zero_m || far || full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      minc[i]  = PW'(mag_r[i]) << s8;
      key_c[i] = (idx_r[i] << sh_r) | (KEY_W'(1) << (sh_r - SH_W'(1)));
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (brk) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
      trunc_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_r == B_RUN);
      last_r  <= (state_r == B_RUN) && brk;
      trunc_r <= (state_r == B_RUN) && full && !zero_m && !far;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE) begin
      idx_r <= q_data.idx;
      bd_r  <= q_data.bd;
      neg_r <= q_data.neg;
      mag_r <= q_data.mag;
      pc_r  <= q_data.pc;
      dm_r  <= q_data.dm;
      sh_r  <= q_data.sh;
      cnt_r <= CNT_W'(1);
    end else if (!brk) begin
      idx_r[ax] <= neg_r[ax] ? idx_r[ax] - KEY_W'(1) : idx_r[ax] + KEY_W'(1);
      bd_r[ax]  <= bd_r[ax] + (BD_W'(1) << s8);
      cnt_r     <= cnt_r + CNT_W'(1);
      unique case (ax)
        2'd0: begin
          pc_r[0] <= pc_r[0] + minc[1];
          pc_r[2] <= pc_r[2] + minc[2];
        end
        2'd1: begin
          pc_r[1] <= pc_r[1] + minc[0];
          pc_r[4] <= pc_r[4] + minc[2];
        end
        default: begin
          pc_r[3] <= pc_r[3] + minc[0];
          pc_r[5] <= pc_r[5] + minc[1];
        end
      endcase
    end
    key_r <= key_c;
  end

  assign out_valid     = valid_r;
  assign out_key_x     = key_r[0];
  assign out_key_y     = key_r[1];
  assign out_key_z     = key_r[2];
  assign out_last      = last_r;
  assign out_truncated = trunc_r;

endmodule

FILE: rtl/core/ray_voxel_traversal.sv
// top level of the ray voxel traversal
// Rays are taken on start while busy is low. Setup of a ray in the front is
// capture, nine products on one shared multiplier and hand-off to a
// two-entry queue; busy is high after the capture until the hand-off, and
// stays high while the queue is full. The back loads a ray, steps the grid
// and emits one cell key per cycle, at most 64 keys per ray, and setup of
// later rays overlaps it. Keys arrive on out_valid for one cycle each, in
// order, out_last on the final one; the receiver cannot stall them. The
// user has cfg_wdata written by cfg_we only while idle, not enforced here.
module ray_voxel_traversal (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         in_origin_x,
  input  logic signed [31:0]         in_origin_y,
  input  logic signed [31:0]         in_origin_z,
  input  logic signed [15:0]         in_dir_x,
  input  logic signed [15:0]         in_dir_y,
  input  logic signed [15:0]         in_dir_z,
  input  logic [30:0]                in_max_distance,
  input  logic                       cfg_we,
  input  logic [rvt_pkg::SH_W-1:0]   cfg_wdata,
  output logic                       out_valid,
  output logic signed [23:0]         out_key_x,
  output logic signed [23:0]         out_key_y,
  output logic signed [23:0]         out_key_z,
  output logic                       out_last,
  output logic                       out_truncated
);
  import rvt_pkg::*;

  logic [SH_W-1:0] cell_shift_r;
  rvt_qctl_t       qc_in, qc_out;
  rvt_ray_t        wr_data, rd_data;
  logic            push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) cell_shift_r <= SH_W'(10);
    else if (cfg_we) cell_shift_r <= cfg_wdata;
  end

  rvt_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_origin_x, .in_origin_y, .in_origin_z,
    .in_dir_x, .in_dir_y, .in_dir_z, .in_max_distance,
    .cell_shift (cell_shift_r),
    .q_full     (qc_out.full),
    .q_push     (push),
    .q_data     (wr_data)
  );

  assign qc_in.push  = push;
  assign qc_in.pop   = pop;
  assign qc_in.full  = 1'b0;
  assign qc_in.empty = 1'b0;

  rvt_queue u_queue (
    .clk, .rst_n,
    .ctl_in  (qc_in),
    .ctl_out (qc_out),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  rvt_back u_back (
    .clk, .rst_n,
    .q_empty       (qc_out.empty),
    .q_pop         (pop),
    .q_data        (rd_data),
    .out_valid,
    .out_key_x,
    .out_key_y,
    .out_key_z,
    .out_last,
    .out_truncated
  );

endmodule

FILE: rtl/core/rvt_checker.sv
// port-level checks for the ray voxel traversal, bound to the top level
`include "ray_voxel_traversal_defines.svh"

module rvt_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last,
  input logic out_truncated
);

  `RVT_ASSERT_SAME(a_trunc_on_last, out_valid && out_truncated, out_last)
  `RVT_ASSERT_SAME(a_flags_need_valid, !out_valid, !out_last && !out_truncated)
  `RVT_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
  `RVT_ASSERT_RESET(a_reset_quiet, !rst_n, !out_valid && !busy)

endmodule

bind ray_voxel_traversal rvt_checker u_rvt_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_last, .out_truncated
);

FILE: sim/tb.sv
// self-checking testbench for the ray voxel traversal: directed and random rays
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
    logic [30:0]        reach;
    logic               is_cfg;
    logic [4:0]         cfg_val;
    logic               drain;
  } ray_t;

  typedef struct {
    logic [23:0] kx, ky, kz;
    logic        last, trunc;
  } key_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic [30:0] in_max_distance = '0;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [23:0] out_key_x, out_key_y, out_key_z;
  logic out_last, out_truncated;

  ray_t pending_rays[$];
  key_t expected_keys[$];
  logic [4:0] shift_reg = 5'd10;
  logic in_taken = 1'b0;
  int errors = 0;
  int rays_sent = 0;
  int keys_seen = 0;
  int truncs_seen = 0;
  int cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  int hold = 0;
  bit stim_done = 1'b0;

  ray_voxel_traversal i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_max_distance(in_max_distance), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_key_x(out_key_x), .out_key_y(out_key_y),
    .out_key_z(out_key_z), .out_last(out_last), .out_truncated(out_truncated)
  );

  always #1 clk = ~clk;

  task automatic add_ray(ray_t r);
    pending_rays = {pending_rays, r};
  endtask

  task automatic add_key(key_t k);
    expected_keys = {expected_keys, k};
  endtask

  function automatic logic [23:0] cell_centre(longint idx, int sh);
    longint c;
    c = idx * (64'sd1 <<< sh) + (64'sd1 <<< (sh - 1));
    return c[23:0];
  endfunction

  // true when the boundary on axis a is strictly nearer than on axis b
  function automatic bit crosses_first(longint unsigned bd[3], longint unsigned mg[3],
                                       int a, int b);
    if (mg[a] == 0) return 1'b0;
    if (mg[b] == 0) return 1'b1;
    return bd[a] * mg[b] < bd[b] * mg[a];
  endfunction

  task automatic predict_cells(ray_t r);
    int sh, n, a;
    longint cq, o, d, lowp;
    longint idx[3], stp[3];
    longint unsigned bd[3], mg[3], reach;
    bit tr;
    key_t k;
    sh = int'(shift_reg);
    if (sh < 1) sh = 1;
    if (sh > 16) sh = 16;
    cq = 64'sd1 <<< (sh + 8);
    reach = 64'(r.reach);
    tr = 1'b0;
    for (int i = 0; i < 3; i++) begin
      o = (i == 0) ? longint'(r.ox) : (i == 1) ? longint'(r.oy) : longint'(r.oz);
      d = (i == 0) ? longint'(r.dx) : (i == 1) ? longint'(r.dy) : longint'(r.dz);
      if (o >= 0) idx[i] = o / cq;
      else idx[i] = -((-o + cq - 1) / cq);
      lowp = o - idx[i] * cq;
      mg[i] = (d < 0) ? -d : d;
      if (d > 0) begin
        stp[i] = 1;
        bd[i] = cq - lowp;
      end else begin
        stp[i] = -1;
        bd[i] = lowp;
      end
    end
    n = 1;
    k.kx = cell_centre(idx[0], sh);
    k.ky = cell_centre(idx[1], sh);
    k.kz = cell_centre(idx[2], sh);
    forever begin
      if (crosses_first(bd, mg, 0, 1)) a = crosses_first(bd, mg, 0, 2) ? 0 : 2;
      else a = crosses_first(bd, mg, 1, 2) ? 1 : 2;
      if (mg[a] == 0) break;
      if (bd[a] * 16384 > reach * mg[a]) break;
      if (n >= 64) begin
        tr = 1'b1;
        break;
      end
      k.last = 1'b0;
      k.trunc = 1'b0;
      add_key(k);
      idx[a] += stp[a];
      bd[a] += cq;
      k.kx = cell_centre(idx[0], sh);
      k.ky = cell_centre(idx[1], sh);
      k.kz = cell_centre(idx[2], sh);
      n++;
    end
    k.last = 1'b1;
    k.trunc = tr;
    add_key(k);
  endtask

  function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                    int reach);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz;
    r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
    r.reach = 31'(reach);
    r.is_cfg = 1'b0; r.cfg_val = '0; r.drain = 1'b0;
    return r;
  endfunction

  function automatic ray_t make_cfg(int v);
    ray_t r;
    r = make_ray(0, 0, 0, 0, 0, 0, 0);
    r.is_cfg = 1'b1;
    r.cfg_val = 5'(v);
    return r;
  endfunction

  function automatic int rand_dir();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16384;
      2: return -16384;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    int o[3];
    for (int i = 0; i < 3; i++)
      case ($urandom_range(0, 4))
        0: o[i] = $urandom;
        1: o[i] = int'($urandom_range(0, 8)) << 18;
        default: o[i] = int'($urandom_range(0, 2000000)) - 1000000;
      endcase
    r = make_ray(o[0], o[1], o[2], rand_dir(), rand_dir(), rand_dir(), 0);
    case ($urandom_range(0, 3))
      0: r.reach = 31'($urandom);
      1: r.reach = 31'($urandom_range(0, 1000));
      default: r.reach = 31'($urandom_range(0, 3000000));
    endcase
    return r;
  endfunction

  initial begin
    add_ray(make_ray(0, 0, 0, 0, 0, 0, 32'h7fffffff));
    add_ray(make_ray(32'h7fffffff, 32'h80000000, -1, 16384, -16384, 0, 1000));
    add_ray(make_ray(32'h80000000, 32'h7fffffff, 0, -16384, 16384, 16384,
                     32'h7fffffff));
    add_ray(make_ray(262144, 262144, 262144, -16384, 0, 0, 0));
    add_ray(make_ray(262144, 0, 0, -16384, -16384, -16384, 300000));
    add_ray(make_ray(100, 100, 100, 9459, 9459, 9459, 5000000));
    add_ray(make_ray(-5, 7, 0, 32767, -32768, 1, 2000000));
    add_ray(make_ray(0, 0, 0, 100, 200, 300, 50000));
    add_ray(make_cfg(1));
    add_ray(make_ray(1, 2, 3, 16384, 8192, 4096, 20000));
    add_ray(make_ray(-1, -1, -1, -16384, -16384, -16384, 32'h7fffffff));
    add_ray(make_cfg(16));
    add_ray(make_ray(32'h7fffffff, 32'h80000000, 5, 16384, -100, 7, 32'h7fffffff));
    add_ray(make_ray(0, 0, 0, 16384, 16384, 16384, 32'h7fffffff));
    add_ray(make_cfg(0));
    add_ray(make_ray(3, -3, 9, 16384, -16384, 8192, 4000));
    add_ray(make_cfg(31));
    add_ray(make_ray(0, 0, 0, -16384, 0, 16384, 32'h7fffffff));
    for (int ph = 0; ph < 6; ph++) begin
      add_ray(make_cfg(ph == 0 ? 10 : ph == 5 ? 1 : int'($urandom_range(0, 31))));
      for (int j = 0; j < 50; j++) begin
        ray_t r;
        r = rand_ray();
        if (j == 25) r.drain = 1'b1;
        add_ray(r);
      end
    end
    stim_done = 1'b1;
  end

  always @(negedge clk) begin : drive
    logic we_nxt;
    we_nxt = 1'b0;
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout at %0t", $time);
      $display("TEST FAILED");
      $finish;
    end
    if (cycles < 7) begin
      rst_n <= 1'b0;
      start <= 1'b0;
    end else begin
      rst_n <= 1'b1;
      if (start) begin
        if (in_taken) start <= 1'b0;
      end else begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_rays.size() > 0) begin
          ray_t r;
          r = pending_rays[0];
          if (r.is_cfg || r.drain) begin
            // wait until the block is drained before a write or a paused transfer
            if (expected_keys.size() != 0 || busy) hold <= 0;
            else if (hold < 80) hold <= hold + 1;
            else begin
              hold <= 0;
              if (r.is_cfg) begin
                void'(pending_rays.pop_front());
                we_nxt = 1'b1;
                cfg_wdata <= r.cfg_val;
                shift_reg <= r.cfg_val;
              end else begin
                pending_rays[0].drain = 1'b0;
              end
            end
          end else begin
            void'(pending_rays.pop_front());
            in_origin_x <= r.ox; in_origin_y <= r.oy; in_origin_z <= r.oz;
            in_dir_x <= r.dx; in_dir_y <= r.dy; in_dir_z <= r.dz;
            in_max_distance <= r.reach;
            start <= 1'b1;
            predict_cells(r);
            rays_sent <= rays_sent + 1;
            if (burst_left > 0) burst_left <= burst_left - 1;
            else begin
              burst_left <= $urandom_range(0, 8);
              gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end
          end
        end else if (stim_done && expected_keys.size() == 0) begin
          if (hold < 100) hold <= hold + 1;
          else begin
            $display("%0d rays, %0d keys, %0d truncated rays, shifts from 0 to 31",
                     rays_sent, keys_seen, truncs_seen);
            if (errors == 0) $display("TEST PASSED");
            else $display("TEST FAILED");
            $finish;
          end
        end
      end
    end
    cfg_we <= we_nxt;
  end

  always @(posedge clk) begin
    in_taken <= start && !busy;
    if (rst_n && out_valid) begin
      keys_seen <= keys_seen + 1;
      if (out_truncated) truncs_seen <= truncs_seen + 1;
      if (expected_keys.size() == 0) begin
        $display("%0t unexpected key transfer %h %h %h", $time, out_key_x, out_key_y,
                 out_key_z);
        errors <= errors + 1;
      end else begin
        key_t e;
        e = expected_keys.pop_front();
        if (e.kx !== out_key_x || e.ky !== out_key_y || e.kz !== out_key_z ||
            e.last !== out_last || e.trunc !== out_truncated) begin
          $display("%0t mismatch exp %h %h %h last %b trunc %b got %h %h %h last %b trunc %b",
                   $time, e.kx, e.ky, e.kz, e.last, e.trunc, out_key_x, out_key_y,
                   out_key_z, out_last, out_truncated);
          errors <= errors + 1;
        end
      end
    end
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rvt_pkg.sv
rtl/core/rvt_front.sv
rtl/core/rvt_queue.sv
rtl/core/rvt_back.sv
rtl/core/ray_voxel_traversal.sv
rtl/core/rvt_checker.sv
sim/tb.sv
